>>> design/multi_window_queue_dispatcher_unit_macros.svh
// ----------------------------------------------------------------------------
// multi_window_queue_dispatcher_unit_macros
// assertion helpers shared by the dispatcher modules
// ----------------------------------------------------------------------------
`ifndef MULTI_WINDOW_QUEUE_DISPATCHER_UNIT_MACROS_SVH
`define MULTI_WINDOW_QUEUE_DISPATCHER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold in the same cycle as the trigger
`define MWQD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define MWQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MWQD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MWQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/mwqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwqd_pkg
// payload types and sequencer states of the queue dispatcher
// ----------------------------------------------------------------------------
package mwqd_pkg;

    localparam int CFG_BITS = 5;

    // one job entering the dispatcher
    typedef struct packed {
        logic [31:0] arrival_time;
        logic [31:0] service_time;
        logic        new_batch;
    } mwqd_job_t;

    // one dispatch result with batch statistics
    typedef struct packed {
        logic [3:0]  server_index;
        logic [31:0] wait_time;
        logic [31:0] finish_time;
        logic [47:0] total_wait;
        logic [31:0] max_wait;
        logic [31:0] latest_finish;
        logic [15:0] job_count;
    } mwqd_result_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_CALC,
        ST_REPORT
    } mwqd_state_t;

endpackage

>>> design/multi_window_queue_dispatcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_window_queue_dispatcher_unit
// earliest-free multi-server dispatcher with running batch statistics
// ----------------------------------------------------------------------------
// sequence: ST_SCAN over the N servers in use, ST_LAST, ST_CALC, then ST_REPORT,
//   which waits for a free output register; one job at a time, the sequencer
//   scanning the single read port of the free-at memory one server per cycle
// reset: all free-at times read zero (valid bits), statistics zero,
//   window_count one; a new batch clears the free-at times at the job transfer
//   and restarts the statistics with its own result
// ----------------------------------------------------------------------------
`include "multi_window_queue_dispatcher_unit_macros.svh"

module multi_window_queue_dispatcher_unit
    import mwqd_pkg::*;
#(
    parameter int MAX_SERVERS = 16,
    parameter int TIME_BITS   = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,
    input  logic                job_valid,
    output logic                job_ready,
    input  mwqd_job_t           job,
    output logic                res_valid,
    input  logic                res_ready,
    output mwqd_result_t        res
);

    localparam int IDX_BITS = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam logic [47:0] SUM_MAX   = '1;
    localparam logic [15:0] COUNT_MAX = '1;

    logic [CFG_BITS-1:0]  window_count_reg;
    logic [47:0]          wait_sum_reg, wait_sum_next;
    logic [TIME_BITS-1:0] wait_peak_reg, wait_peak_next;
    logic [TIME_BITS-1:0] finish_peak_reg, finish_peak_next;
    logic [15:0]          jobs_seen_reg, jobs_seen_next;
    logic                 res_valid_reg;
    mwqd_result_t         res_reg, res_next;

    logic                 slot_free;
    logic                 done;
    logic                 done_new_batch;
    logic [IDX_BITS-1:0]  done_pick;
    logic [TIME_BITS-1:0] done_wait, done_finish;
    logic                 ram_clear, ram_rd_en, ram_wr_en;
    logic [IDX_BITS-1:0]  ram_rd_addr, ram_wr_addr;
    logic [TIME_BITS-1:0] ram_rd_data, ram_wr_data;

    logic [47:0]          sum_base;
    logic [48:0]          sum_wide;
    logic [TIME_BITS-1:0] peak_base, fpeak_base;
    logic [15:0]          jobs_base;
    logic [63:0]          wait64, finish64, wpeak64, fpeak64;
    logic [7:0]           pick8;

    mwqd_time_ram #(
        .DEPTH     (MAX_SERVERS),
        .TIME_BITS (TIME_BITS),
        .IDX_BITS  (IDX_BITS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (ram_clear),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    mwqd_ctrl #(
        .MAX_SERVERS (MAX_SERVERS),
        .TIME_BITS   (TIME_BITS),
        .IDX_BITS    (IDX_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .job            (job),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .window_count   (window_count_reg),
        .slot_free      (slot_free),
        .done           (done),
        .done_new_batch (done_new_batch),
        .done_pick      (done_pick),
        .done_wait      (done_wait),
        .done_finish    (done_finish),
        .ram_clear      (ram_clear),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data)
    );

    // output register frees when empty or being taken
    assign slot_free = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // batch statistics, cleared first on a new batch
    always_comb
    begin
        sum_base   = done_new_batch ? '0 : wait_sum_reg;
        peak_base  = done_new_batch ? '0 : wait_peak_reg;
        fpeak_base = done_new_batch ? '0 : finish_peak_reg;
        jobs_base  = done_new_batch ? '0 : jobs_seen_reg;

        sum_wide         = {1'b0, sum_base} + 49'(done_wait);
        wait_sum_next    = sum_wide[48] ? SUM_MAX : sum_wide[47:0];
        wait_peak_next   = (done_wait > peak_base) ? done_wait : peak_base;
        finish_peak_next = (done_finish > fpeak_base) ? done_finish : fpeak_base;
        jobs_seen_next   = (jobs_base == COUNT_MAX) ? jobs_base : (jobs_base + 16'd1);
    end

    // result assembly
    always_comb
    begin
        pick8    = 8'(done_pick);
        wait64   = 64'(done_wait);
        finish64 = 64'(done_finish);
        wpeak64  = 64'(wait_peak_next);
        fpeak64  = 64'(finish_peak_next);

        res_next.server_index  = pick8[3:0];
        res_next.wait_time     = wait64[31:0];
        res_next.finish_time   = finish64[31:0];
        res_next.total_wait    = wait_sum_next;
        res_next.max_wait      = wpeak64[31:0];
        res_next.latest_finish = fpeak64[31:0];
        res_next.job_count     = jobs_seen_next;
    end

    // configuration, statistics and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count_reg <= CFG_BITS'(1);
            wait_sum_reg     <= '0;
            wait_peak_reg    <= '0;
            finish_peak_reg  <= '0;
            jobs_seen_reg    <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_count_reg <= cfg_wr_data;
            end
            if (done)
            begin
                wait_sum_reg    <= wait_sum_next;
                wait_peak_reg   <= wait_peak_next;
                finish_peak_reg <= finish_peak_next;
                jobs_seen_reg   <= jobs_seen_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg <= res_next;
        end
    end

    `MWQD_ASSERT_SAME(a_done_slot_free, clk, rst_n, done, !res_valid_reg || res_ready, "result loaded over an untaken result")
    `MWQD_ASSERT_NEXT(a_count_nonzero, clk, rst_n, done, jobs_seen_reg != 16'd0, "job count zero after a dispatch")
    `MWQD_ASSERT_NEXT(a_peak_grows, clk, rst_n, done && !done_new_batch, wait_peak_reg >= $past(wait_peak_reg), "wait peak fell within a batch")

endmodule

>>> design/mwqd_time_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwqd_time_ram
// free-at time memory, one read and one write port, registered read data;
// per-entry valid bits make a never-written or cleared entry read as zero
// ----------------------------------------------------------------------------
module mwqd_time_ram
    import mwqd_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32,
    parameter int IDX_BITS  = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 rd_en,
    input  logic [IDX_BITS-1:0]  rd_addr,
    output logic [TIME_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [IDX_BITS-1:0]  wr_addr,
    input  logic [TIME_BITS-1:0] wr_data
);

    logic [TIME_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [TIME_BITS-1:0] rd_data_reg;
    logic                 rd_hit_reg;

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits, cleared by reset or a new batch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

>>> design/mwqd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwqd_ctrl
// job sequencer: scans the free-at memory, picks a server and computes
// the wait and finish time, then writes the new free-at time back
// ----------------------------------------------------------------------------
`include "multi_window_queue_dispatcher_unit_macros.svh"

module mwqd_ctrl
    import mwqd_pkg::*;
#(
    parameter int MAX_SERVERS = 16,
    parameter int TIME_BITS   = 32,
    parameter int IDX_BITS    = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mwqd_job_t            job,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  logic [CFG_BITS-1:0]  window_count,
    input  logic                 slot_free,
    output logic                 done,
    output logic                 done_new_batch,
    output logic [IDX_BITS-1:0]  done_pick,
    output logic [TIME_BITS-1:0] done_wait,
    output logic [TIME_BITS-1:0] done_finish,
    output logic                 ram_clear,
    output logic                 ram_rd_en,
    output logic [IDX_BITS-1:0]  ram_rd_addr,
    input  logic [TIME_BITS-1:0] ram_rd_data,
    output logic                 ram_wr_en,
    output logic [IDX_BITS-1:0]  ram_wr_addr,
    output logic [TIME_BITS-1:0] ram_wr_data
);

    localparam int EXT_BITS = TIME_BITS + 33;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    mwqd_state_t          state_reg, state_next;
    logic [IDX_BITS-1:0]  issue_idx_reg;
    logic [IDX_BITS-1:0]  last_idx_reg;
    logic                 cmp_valid_reg;
    logic [IDX_BITS-1:0]  cmp_idx_reg;
    logic [TIME_BITS-1:0] arr_reg, svc_reg;
    logic                 nb_reg;
    logic                 found_reg;
    logic [IDX_BITS-1:0]  free_idx_reg;
    logic [TIME_BITS-1:0] min_reg;
    logic [IDX_BITS-1:0]  min_idx_reg;
    logic [IDX_BITS-1:0]  pick_reg;
    logic [TIME_BITS-1:0] wait_reg, finish_reg;

    logic                 accept;
    logic [EXT_BITS-1:0]  arr_ext, svc_ext;
    logic [TIME_BITS-1:0] arr_clamp, svc_clamp;
    logic [7:0]           wc_ext, used8;
    logic [TIME_BITS-1:0] base_time;
    logic [TIME_BITS:0]   finish_sum;
    logic [TIME_BITS-1:0] finish_clamp;

    assign accept = job_valid && job_ready;

    // saturate incoming times to the time range
    always_comb
    begin
        arr_ext   = EXT_BITS'(job.arrival_time);
        svc_ext   = EXT_BITS'(job.service_time);
        arr_clamp = (arr_ext > EXT_BITS'(TIME_MAX)) ? TIME_MAX : arr_ext[TIME_BITS-1:0];
        svc_clamp = (svc_ext > EXT_BITS'(TIME_MAX)) ? TIME_MAX : svc_ext[TIME_BITS-1:0];
    end

    // servers in use, limited to one through the built maximum
    always_comb
    begin
        wc_ext = 8'(window_count);
        if (wc_ext == 8'd0)
        begin
            used8 = 8'd1;
        end
        else if (wc_ext > 8'(MAX_SERVERS))
        begin
            used8 = 8'(MAX_SERVERS);
        end
        else
        begin
            used8 = wc_ext;
        end
    end

    // finish time from the chosen start, saturating
    always_comb
    begin
        base_time    = found_reg ? arr_reg : min_reg;
        finish_sum   = {1'b0, base_time} + {1'b0, svc_reg};
        finish_clamp = finish_sum[TIME_BITS] ? TIME_MAX : finish_sum[TIME_BITS-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_idx_reg == last_idx_reg)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        job_ready   = 1'b0;
        ram_rd_en   = 1'b0;
        done        = 1'b0;
        case (state_reg)
            ST_IDLE:   job_ready = 1'b1;
            ST_SCAN:   ram_rd_en = 1'b1;
            ST_REPORT: done      = slot_free;
            default:   job_ready = 1'b0;
        endcase
    end

    assign ram_clear      = accept && job.new_batch;
    assign ram_rd_addr    = issue_idx_reg;
    assign ram_wr_en      = done;
    assign ram_wr_addr    = pick_reg;
    assign ram_wr_data    = finish_reg;
    assign done_new_batch = nb_reg;
    assign done_pick      = pick_reg;
    assign done_wait      = wait_reg;
    assign done_finish    = finish_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_idx_reg <= '0;
            last_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg   <= issue_idx_reg;
            if (accept)
            begin
                issue_idx_reg <= '0;
                last_idx_reg  <= IDX_BITS'(used8 - 8'd1);
                found_reg     <= 1'b0;
            end
            else
            begin
                if (state_reg == ST_SCAN)
                begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                end
                if (cmp_valid_reg && !found_reg && (ram_rd_data <= arr_reg))
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // job payload and scan results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arr_reg <= arr_clamp;
            svc_reg <= svc_clamp;
            nb_reg  <= job.new_batch;
        end
        // first free server and earliest free-at, lowest index on ties
        if (cmp_valid_reg)
        begin
            if (!found_reg && (ram_rd_data <= arr_reg))
            begin
                free_idx_reg <= cmp_idx_reg;
            end
            if ((cmp_idx_reg == '0) || (ram_rd_data < min_reg))
            begin
                min_reg     <= ram_rd_data;
                min_idx_reg <= cmp_idx_reg;
            end
        end
        if (state_reg == ST_CALC)
        begin
            pick_reg   <= found_reg ? free_idx_reg : min_idx_reg;
            wait_reg   <= found_reg ? '0 : (min_reg - arr_reg);
            finish_reg <= finish_clamp;
        end
    end

    `MWQD_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, accept, state_reg == ST_SCAN, "accepted job did not start a scan")
    `MWQD_ASSERT_SAME(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN, issue_idx_reg <= last_idx_reg, "scan address past the servers in use")
    `MWQD_ASSERT_SAME(a_busy_min_late, clk, rst_n, (state_reg == ST_CALC) && !found_reg, min_reg > arr_reg, "no free server but earliest free-at not after arrival")

endmodule
